// ===== sv/csta_pkg.sv =====
package csta_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DOWN    = 2'd1,
    OP_UP      = 2'd2,
    OP_DESTROY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADSLOT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  localparam int unsigned IdWidth   = 6;
  localparam int unsigned InitWidth = 16;
  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned WokeWidth = 8;

endpackage

// ===== sv/csta_ram.sv =====
module csta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/counting_semaphore_table_unit.sv =====
// Channel | Direction | Handshake             | Fields
// --------+-----------+-----------------------+------------------------------------------
// in      | input     | in_valid_i/in_stall_o | operation, sem_id, initial_value, create_key
// out     | output    | out_valid_o/out_stall_i | status, slot, must_wait, wake_all, woken_count
//
// The accept cycle issues the slot read; the execute state then gets the read
// data, updates the entry, writes it back and loads the result. No new item
// is taken while an item is in execute; the slot memory read is registered.
// Reset clears the in-use bits and the live count at once; no clearing pass.
// A new item is taken while a result waits; if that result is still stalled,
// the next item holds in execute until the output register frees up.
module counting_semaphore_table_unit #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned COUNT_WIDTH  = 16,
  parameter int unsigned WAITER_WIDTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             operation_i,
  input  logic [csta_pkg::IdWidth-1:0]           sem_id_i,
  input  logic signed [csta_pkg::InitWidth-1:0]  initial_value_i,
  input  logic [csta_pkg::KeyWidth-1:0]          create_key_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             status_o,
  output logic [csta_pkg::IdWidth-1:0]           slot_o,
  output logic                                   must_wait_o,
  output logic                                   wake_all_o,
  output logic [csta_pkg::WokeWidth-1:0]         woken_count_o
);

  import csta_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  // id compare width: holds sem_id and SLOTS itself
  localparam int unsigned IW = ((AW > IdWidth) ? AW : IdWidth) + 1;
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned WW = WAITER_WIDTH;
  localparam int unsigned MW = KeyWidth + WW + CW;
  // narrowest of init width and count width, for the range check
  localparam int unsigned SW = (CW < InitWidth) ? CW : InitWidth;

  localparam logic [CW-1:0] CntMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CntMin = {1'b1, {(CW-1){1'b0}}};
  localparam logic [WW-1:0] WaitMax = {WW{1'b1}};

  // ---------------------------------------------------------------------------
  // Control and captured request
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic                       in_accept;
  logic                       commit;
  logic [IW-1:0]              id_ext;

  op_e                        op_q;
  logic [AW-1:0]              addr_q;
  logic                       in_range_q;
  logic signed [InitWidth-1:0] init_q;
  logic [KeyWidth-1:0]        key_q;

  // slot occupancy, live count and registered lowest free slot
  logic [SLOTS-1:0]           in_use_q, in_use_d;
  logic [LW-1:0]              live_q, live_d;
  logic [AW-1:0]              free_q, free_d;

  // slot memory: {key, waiters, count}
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [MW-1:0]              mem_wdata;
  logic [MW-1:0]              mem_rdata;

  logic [KeyWidth-1:0]        rd_key;
  logic [WW-1:0]              rd_wait;
  logic [CW-1:0]              rd_cnt;

  // result path
  logic                       out_valid_q, out_valid_d;
  status_e                    status_q, status_d;
  logic [IdWidth-1:0]         slot_q, slot_d;
  logic                       must_wait_q, must_wait_d;
  logic                       wake_all_q, wake_all_d;
  logic [WokeWidth-1:0]       woken_q, woken_d;

  logic                       table_full;
  logic                       init_fits;
  logic                       slot_live;
  logic [CW-1:0]              cnt_dec, cnt_inc;
  logic [16:0]                wait_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // execute finishes only when the output register can take the result
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign id_ext     = IW'(sem_id_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_accept) state_d = S_EXEC;
      S_EXEC:  if (commit)    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      live_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      live_q      <= live_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= op_e'(operation_i);
      addr_q     <= id_ext[AW-1:0];
      in_range_q <= (id_ext < IW'(SLOTS));
      init_q     <= initial_value_i;
      key_q      <= create_key_i;
    end
    if (commit) begin
      status_q    <= status_d;
      slot_q      <= slot_d;
      must_wait_q <= must_wait_d;
      wake_all_q  <= wake_all_d;
      woken_q     <= woken_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Lowest free slot. Registered every cycle; the in-use bits only change in
  // execute and the accept cycle sits in between, so it is current by the
  // time a create executes.
  // ---------------------------------------------------------------------------
  always_comb begin
    free_d = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) free_d = AW'(i);
    end
  end

  assign table_full = (live_q == LW'(SLOTS));

  // ---------------------------------------------------------------------------
  // Slot memory, read on accept, written back on commit
  // ---------------------------------------------------------------------------
  csta_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (id_ext[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd_cnt  = mem_rdata[CW-1:0];
  assign rd_wait = mem_rdata[CW+WW-1:CW];
  assign rd_key  = mem_rdata[MW-1:CW+WW];

  // initial value must be representable in the count width
  assign init_fits = (init_q[InitWidth-1:SW-1] == '0) ||
                     (init_q[InitWidth-1:SW-1] == '1);
  assign slot_live = in_range_q && in_use_q[addr_q];
  assign cnt_dec   = rd_cnt - 1'b1;
  assign cnt_inc   = rd_cnt + 1'b1;
  assign wait_wide = 17'(rd_wait);

  // ---------------------------------------------------------------------------
  // Execute: decide the request, form the write-back and the result
  // ---------------------------------------------------------------------------
  always_comb begin
    in_use_d    = in_use_q;
    live_d      = live_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = mem_rdata;
    status_d    = ST_OK;
    slot_d      = '0;
    must_wait_d = 1'b0;
    wake_all_d  = 1'b0;
    woken_d     = '0;

    if (commit) begin
      if (op_q == OP_CREATE) begin
        if (table_full) begin
          status_d = ST_FULL;
        end else if (!init_fits) begin
          status_d = ST_OVERFLOW;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = free_q;
          mem_wdata        = {key_q, {WW{1'b0}}, CW'(init_q)};
          in_use_d[free_q] = 1'b1;
          live_d           = live_q + 1'b1;
          slot_d           = IdWidth'(free_q);
        end
      end else if (!slot_live) begin
        status_d = ST_BADSLOT;
      end else begin
        case (op_q)
          OP_DOWN: begin
            if (rd_cnt == CntMin) begin
              status_d = ST_OVERFLOW;
            end else if (cnt_dec[CW-1] && (rd_wait == WaitMax)) begin
              // would need one more waiter than the counter holds
              status_d = ST_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              if (cnt_dec[CW-1]) begin
                mem_wdata   = {rd_key, rd_wait + 1'b1, cnt_dec};
                must_wait_d = 1'b1;
              end else begin
                mem_wdata = {rd_key, rd_wait, cnt_dec};
              end
            end
          end
          OP_UP: begin
            if (rd_cnt == CntMax) begin
              status_d = ST_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              if (!cnt_inc[CW-1] && (rd_wait != '0)) begin
                mem_wdata  = {rd_key, {WW{1'b0}}, cnt_inc};
                wake_all_d = 1'b1;
                woken_d    = (wait_wide > 17'd255) ? {WokeWidth{1'b1}}
                                                   : wait_wide[WokeWidth-1:0];
              end else begin
                mem_wdata = {rd_key, rd_wait, cnt_inc};
              end
            end
          end
          default: begin
            // destroy: waiters are dropped, entry is rewritten when a create takes the slot
            in_use_d[addr_q] = 1'b0;
            live_d           = live_q - 1'b1;
          end
        endcase
      end
    end
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign must_wait_o   = must_wait_q;
  assign wake_all_o    = wake_all_q;
  assign woken_count_o = woken_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_live_matches_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == LW'($countones(in_use_q)))
    else $error("live count differs from in-use bits");

  a_create_takes_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q == OP_CREATE) && !table_full) |-> !in_use_q[free_q])
    else $error("create picked a slot already in use");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_EXEC))
    else $error("result appeared without an execute cycle");

endmodule
